### src/hfa_pkg.sv
package hfa_pkg;

  // default geometry
  localparam int HEAP_UNITS_DEF  = 128;
  localparam int MAX_EXTENTS_DEF = 64;
  localparam int MAX_ALLOCS_DEF  = 64;
  localparam int TAG_BITS_DEF    = 8;

  // command codes
  localparam logic [1:0] CMD_FIRST = 2'd0;
  localparam logic [1:0] CMD_NEXT  = 2'd1;
  localparam logic [1:0] CMD_BEST  = 2'd2;
  localparam logic [1:0] CMD_FREE  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EXISTS   = 3'd1;
  localparam logic [2:0] ST_NOSPACE  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // extent chain operations
  typedef enum logic [2:0] {
    EOP_HOLD = 3'd0,
    EOP_ROT  = 3'd1,  // every cell takes its upper neighbor, ring closes
    EOP_SET  = 3'd2,  // cell idx takes the broadcast extent
    EOP_INS  = 3'd3,  // cell idx takes broadcast, cells above shift up
    EOP_DEL  = 3'd4,  // cells at and above idx shift down
    EOP_MRG  = 3'd5   // cell idx-1 takes broadcast, cells at and above idx shift down
  } ext_op_t;

  // allocation chain operations
  typedef enum logic [1:0] {
    SOP_HOLD  = 2'd0,
    SOP_ROT   = 2'd1,
    SOP_WRITE = 2'd2,
    SOP_CLEAR = 2'd3
  } slot_op_t;

endpackage

### src/hfa_ext_cell.sv
module hfa_ext_cell import hfa_pkg::*; #(
  parameter int PW        = 7,
  parameter int EI        = 6,
  parameter int IDX       = 0,
  parameter int INIT_LAST = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ext_op_t       op,
  input  logic [EI-1:0] op_idx,
  input  logic [PW-1:0] op_start,
  input  logic [PW-1:0] op_last,
  input  logic [PW-1:0] nxt_start,
  input  logic [PW-1:0] nxt_last,
  input  logic [PW-1:0] prv_start,
  input  logic [PW-1:0] prv_last,
  output logic [PW-1:0] start,
  output logic [PW-1:0] last
);

  localparam logic [EI-1:0] MY = EI'(IDX);

  logic [PW-1:0] start_r, last_r;
  logic          is_left;

  // this cell sits just below the broadcast index
  assign is_left = ({1'b0, MY} + (EI+1)'(1)) == {1'b0, op_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      last_r  <= PW'(INIT_LAST);
    end else begin
      unique case (op)
        EOP_HOLD: begin
        end
        EOP_ROT: begin
          start_r <= nxt_start;
          last_r  <= nxt_last;
        end
        EOP_SET: begin
          if (MY == op_idx) begin
            start_r <= op_start;
            last_r  <= op_last;
          end
        end
        EOP_INS: begin
          if (MY == op_idx) begin
            start_r <= op_start;
            last_r  <= op_last;
          end else if (MY > op_idx) begin
            start_r <= prv_start;
            last_r  <= prv_last;
          end
        end
        EOP_DEL: begin
          if (MY >= op_idx) begin
            start_r <= nxt_start;
            last_r  <= nxt_last;
          end
        end
        EOP_MRG: begin
          if (is_left) begin
            start_r <= op_start;
            last_r  <= op_last;
          end else if (MY >= op_idx) begin
            start_r <= nxt_start;
            last_r  <= nxt_last;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign start = start_r;
  assign last  = last_r;

endmodule

### src/hfa_slot_cell.sv
module hfa_slot_cell import hfa_pkg::*; #(
  parameter int TW  = 8,
  parameter int PW  = 7,
  parameter int AI  = 6,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  slot_op_t      op,
  input  logic [AI-1:0] op_idx,
  input  logic [TW-1:0] op_tag,
  input  logic [PW-1:0] op_start,
  input  logic [PW-1:0] op_last,
  input  logic          nxt_valid,
  input  logic [TW-1:0] nxt_tag,
  input  logic [PW-1:0] nxt_start,
  input  logic [PW-1:0] nxt_last,
  output logic          valid,
  output logic [TW-1:0] tag,
  output logic [PW-1:0] start,
  output logic [PW-1:0] last
);

  localparam logic [AI-1:0] MY = AI'(IDX);

  logic          valid_r;
  logic [TW-1:0] tag_r;
  logic [PW-1:0] start_r, last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      unique case (op)
        SOP_HOLD: begin
        end
        SOP_ROT: begin
          valid_r <= nxt_valid;
          tag_r   <= nxt_tag;
          start_r <= nxt_start;
          last_r  <= nxt_last;
        end
        SOP_WRITE: begin
          if (MY == op_idx) begin
            valid_r <= 1'b1;
            tag_r   <= op_tag;
            start_r <= op_start;
            last_r  <= op_last;
          end
        end
        SOP_CLEAR: begin
          if (MY == op_idx) valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign valid = valid_r;
  assign tag   = tag_r;
  assign start = start_r;
  assign last  = last_r;

endmodule

### src/heap_fit_allocator_core.sv
// Extent allocator over a heap of HEAP_UNITS units.
// Command channel: in_command/in_tag/in_size are taken as one beat at a
// rising edge with start high and busy low. busy stays high until the
// result strobe cycle, in which it is already low.
// Result channel: out_valid strobes for exactly one cycle with out_status,
// out_block_start and out_block_last. The receiver cannot hold it off.
// One result beat per command beat, in order.
// Storage: the free-extent list and the allocation slots are two rows of
// cells. A scan rotates a row by one cell per cycle and looks at cell 0;
// after a full turn the row is back in place. Inserts, removes and merges
// are neighbor shifts done in the update state, selected by a broadcast index.
// Sequence: slot scan, decide state, extent scan, update state. Errors
// known after the slot scan (tag exists, table full, bad size, tag not
// found) are strobed from the decide state; other commands are strobed
// from the update state. A new command can be taken at the edge that
// ends the strobe; the time per command is set by the two rotations
// (only the slot rotation on an early error).
// Reset (rst_n low, synchronous): one free extent covering the whole heap,
// all slots empty, rover zero, no result pending.
module heap_fit_allocator_core import hfa_pkg::*; #(
  parameter int HEAP_UNITS  = HEAP_UNITS_DEF,
  parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
  parameter int MAX_ALLOCS  = MAX_ALLOCS_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_command,
  input  logic [7:0] in_tag,
  input  logic [7:0] in_size,
  output logic       out_valid,
  output logic [2:0] out_status,
  output logic [6:0] out_block_start,
  output logic [6:0] out_block_last
);

  localparam int PW = $clog2(HEAP_UNITS);       // unit position
  localparam int LW = $clog2(HEAP_UNITS + 1);   // extent length
  localparam int EI = $clog2(MAX_EXTENTS);
  localparam int AI = $clog2(MAX_ALLOCS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int TW = TAG_BITS;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ASCAN = 5'b00010,
    S_ADEC  = 5'b00100,
    S_ESCAN = 5'b01000,
    S_APPLY = 5'b10000
  } state_t;

  function automatic logic [6:0] to_port(input logic [PW-1:0] p);
    logic [PW+6:0] t;
    t = {7'b0, p};
    return t[6:0];
  endfunction

  state_t state_r, state_nxt;

  // command beat
  logic [1:0]    cmd_r;
  logic [TW-1:0] tag_r;
  logic [LW-1:0] size_r;
  logic          bad_r;
  logic [TW+7:0] tag_pad;
  logic          acc;

  // global state
  logic [CW-1:0] count_r;
  logic [PW-1:0] rover_r;

  // scan bookkeeping
  logic [AI-1:0] ak_r;
  logic [EI-1:0] ek_r;
  logic          hit_f_r, emp_f_r;
  logic [AI-1:0] hit_idx_r, emp_idx_r;
  logic [PW-1:0] hs_r, hl_r;
  logic          pf_r, nf_r;
  logic [EI-1:0] pidx_r, nidx_r;
  logic [PW-1:0] pst_r, pla_r, nst_r, nla_r;
  logic [LW-1:0] plen_r, nlen_r;
  logic          ff_r;
  logic [CW-1:0] fp_r;
  logic [PW-1:0] fpst_r, fpla_r, prv_st_r, prv_la_r;

  // result register
  logic          out_valid_r;
  logic [2:0]    out_status_r;
  logic [6:0]    out_bs_r, out_bl_r;

  // chains
  ext_op_t       eop;
  logic [EI-1:0] eidx;
  logic [PW-1:0] est, ela;
  slot_op_t      sop;
  logic [AI-1:0] sidx;
  logic [PW-1:0] sst, sla;

  logic [PW-1:0] es [MAX_EXTENTS];
  logic [PW-1:0] el [MAX_EXTENTS];
  logic          sv [MAX_ALLOCS];
  logic [TW-1:0] stg [MAX_ALLOCS];
  logic [PW-1:0] ss [MAX_ALLOCS];
  logic [PW-1:0] sl [MAX_ALLOCS];

  genvar gi;
  generate
    for (gi = 0; gi < MAX_EXTENTS; gi++) begin : g_ext
      hfa_ext_cell #(
        .PW(PW), .EI(EI), .IDX(gi), .INIT_LAST((gi == 0) ? HEAP_UNITS - 1 : 0)
      ) u_cell (
        .clk(clk), .rst_n(rst_n), .op(eop), .op_idx(eidx),
        .op_start(est), .op_last(ela),
        .nxt_start(es[(gi + 1) % MAX_EXTENTS]), .nxt_last(el[(gi + 1) % MAX_EXTENTS]),
        .prv_start(es[(gi + MAX_EXTENTS - 1) % MAX_EXTENTS]),
        .prv_last(el[(gi + MAX_EXTENTS - 1) % MAX_EXTENTS]),
        .start(es[gi]), .last(el[gi])
      );
    end
    for (gi = 0; gi < MAX_ALLOCS; gi++) begin : g_slot
      hfa_slot_cell #(
        .TW(TW), .PW(PW), .AI(AI), .IDX(gi)
      ) u_cell (
        .clk(clk), .rst_n(rst_n), .op(sop), .op_idx(sidx),
        .op_tag(tag_r), .op_start(sst), .op_last(sla),
        .nxt_valid(sv[(gi + 1) % MAX_ALLOCS]), .nxt_tag(stg[(gi + 1) % MAX_ALLOCS]),
        .nxt_start(ss[(gi + 1) % MAX_ALLOCS]), .nxt_last(sl[(gi + 1) % MAX_ALLOCS]),
        .valid(sv[gi]), .tag(stg[gi]), .start(ss[gi]), .last(sl[gi])
      );
    end
  endgenerate

  assign busy    = (state_r != S_IDLE);
  assign acc     = start && !busy;
  assign tag_pad = {TW'(0), in_tag};

  // head of the extent row during a scan
  logic [LW-1:0] h_len;
  logic          h_in, h_fits;
  assign h_len  = LW'(el[0]) - LW'(es[0]) + LW'(1);
  assign h_in   = CW'(ek_r) < count_r;
  assign h_fits = h_len >= size_r;

  // update-cycle decisions
  logic          a_ok;
  logic [EI-1:0] a_idx;
  logic [PW-1:0] a_st, a_la;
  logic [LW-1:0] a_len, a_end;
  logic          f_left, f_right, f_full;

  always_comb begin
    a_ok  = pf_r || nf_r;
    a_idx = pf_r ? pidx_r : nidx_r;
    a_st  = pf_r ? pst_r  : nst_r;
    a_la  = pf_r ? pla_r  : nla_r;
    a_len = pf_r ? plen_r : nlen_r;
    a_end = LW'(a_st) + size_r - LW'(1);
    f_left  = (fp_r != '0) && ((LW'(prv_la_r) + LW'(1)) == LW'(hs_r));
    f_right = ff_r && ((LW'(hl_r) + LW'(1)) == LW'(fpst_r));
    f_full  = (count_r == CW'(MAX_EXTENTS));
  end

  // chain control
  always_comb begin
    eop  = EOP_HOLD;
    eidx = '0;
    est  = '0;
    ela  = '0;
    sop  = SOP_HOLD;
    sidx = '0;
    sst  = '0;
    sla  = '0;
    unique case (state_r)
      S_ASCAN: sop = SOP_ROT;
      S_ESCAN: eop = EOP_ROT;
      S_APPLY: begin
        if (cmd_r == CMD_FREE) begin
          sidx = hit_idx_r;
          if (f_left && f_right) begin
            eop  = EOP_MRG;
            eidx = EI'(fp_r);
            est  = prv_st_r;
            ela  = fpla_r;
            sop  = SOP_CLEAR;
          end else if (f_left) begin
            eop  = EOP_SET;
            eidx = EI'(fp_r - CW'(1));
            est  = prv_st_r;
            ela  = hl_r;
            sop  = SOP_CLEAR;
          end else if (f_right) begin
            eop  = EOP_SET;
            eidx = EI'(fp_r);
            est  = hs_r;
            ela  = fpla_r;
            sop  = SOP_CLEAR;
          end else if (!f_full) begin
            eop  = EOP_INS;
            eidx = EI'(fp_r);
            est  = hs_r;
            ela  = hl_r;
            sop  = SOP_CLEAR;
          end
        end else if (a_ok) begin
          eidx = a_idx;
          est  = PW'(a_end + LW'(1));
          ela  = a_la;
          eop  = (a_len == size_r) ? EOP_DEL : EOP_SET;
          sop  = SOP_WRITE;
          sidx = emp_idx_r;
          sst  = a_st;
          sla  = PW'(a_end);
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (acc) state_nxt = S_ASCAN;
      S_ASCAN: if (ak_r == AI'(MAX_ALLOCS - 1)) state_nxt = S_ADEC;
      S_ADEC: begin
        if (cmd_r == CMD_FREE) state_nxt = hit_f_r ? S_ESCAN : S_IDLE;
        else if (hit_f_r || !emp_f_r || bad_r) state_nxt = S_IDLE;
        else state_nxt = S_ESCAN;
      end
      S_ESCAN: if (ek_r == EI'(MAX_EXTENTS - 1)) state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CW'(1);
      rover_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            cmd_r   <= in_command;
            tag_r   <= tag_pad[TW-1:0];
            size_r  <= LW'(in_size);
            bad_r   <= (in_size == 8'd0) || (32'(in_size) > 32'(HEAP_UNITS));
            ak_r    <= '0;
            hit_f_r <= 1'b0;
            emp_f_r <= 1'b0;
          end
        end
        S_ASCAN: begin
          ak_r <= ak_r + AI'(1);
          if (sv[0] && stg[0] == tag_r && !hit_f_r) begin
            hit_f_r   <= 1'b1;
            hit_idx_r <= ak_r;
            hs_r      <= ss[0];
            hl_r      <= sl[0];
          end
          if (!sv[0] && !emp_f_r) begin
            emp_f_r   <= 1'b1;
            emp_idx_r <= ak_r;
          end
        end
        S_ADEC: begin
          ek_r <= '0;
          pf_r <= 1'b0;
          nf_r <= 1'b0;
          ff_r <= 1'b0;
          fp_r <= count_r;
          out_bs_r <= '0;
          out_bl_r <= '0;
          if (cmd_r == CMD_FREE) begin
            if (!hit_f_r) begin
              out_valid_r  <= 1'b1;
              out_status_r <= ST_NOTFOUND;
            end
          end else if (hit_f_r) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_EXISTS;
          end else if (!emp_f_r) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_FULL;
          end else if (bad_r) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_NOSPACE;
          end
        end
        S_ESCAN: begin
          ek_r <= ek_r + EI'(1);
          if (cmd_r == CMD_FREE) begin
            // find the first extent at or above the returned block
            if (h_in && !ff_r) begin
              if (es[0] >= hs_r) begin
                ff_r   <= 1'b1;
                fp_r   <= CW'(ek_r);
                fpst_r <= es[0];
                fpla_r <= el[0];
              end else begin
                prv_st_r <= es[0];
                prv_la_r <= el[0];
              end
            end
          end else if (h_in && h_fits) begin
            priority if (cmd_r == CMD_BEST) begin
              if (!pf_r || h_len < plen_r) begin
                pf_r   <= 1'b1;
                pidx_r <= ek_r;
                pst_r  <= es[0];
                pla_r  <= el[0];
                plen_r <= h_len;
              end
            end else begin
              // first fit: p is the first that fits; next fit: p is the first at or above the rover, n the wrap choice
              if (!pf_r && (cmd_r == CMD_FIRST || es[0] >= rover_r)) begin
                pf_r   <= 1'b1;
                pidx_r <= ek_r;
                pst_r  <= es[0];
                pla_r  <= el[0];
                plen_r <= h_len;
              end
              if (!nf_r && cmd_r == CMD_NEXT) begin
                nf_r   <= 1'b1;
                nidx_r <= ek_r;
                nst_r  <= es[0];
                nla_r  <= el[0];
                nlen_r <= h_len;
              end
            end
          end
        end
        S_APPLY: begin
          out_valid_r <= 1'b1;
          if (cmd_r == CMD_FREE) begin
            if (!f_left && !f_right && f_full) begin
              out_status_r <= ST_FULL;
            end else begin
              out_status_r <= ST_OK;
              out_bs_r     <= to_port(hs_r);
              out_bl_r     <= to_port(hl_r);
              if (f_left && f_right) count_r <= count_r - CW'(1);
              else if (!f_left && !f_right) count_r <= count_r + CW'(1);
            end
          end else if (!a_ok) begin
            out_status_r <= ST_NOSPACE;
          end else begin
            out_status_r <= ST_OK;
            out_bs_r     <= to_port(a_st);
            out_bl_r     <= to_port(PW'(a_end));
            rover_r      <= PW'(a_end);
            if (a_len == size_r) count_r <= count_r - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_block_start = out_bs_r;
  assign out_block_last  = out_bl_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_EXTENTS))
    else $error("extent count above table size");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> !out_valid_r)
    else $error("result right after command beat");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_bs_r == '0 && out_bl_r == '0))
    else $error("error result carries a block");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result shown while busy");

endmodule
